>>> rtl/core/ppic_pkg.sv
`default_nettype none
package ppic_pkg;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 3;

    localparam logic [2:0] MFR_ID_RESET  = 3'd5;
    localparam logic       REFRESH_RESET = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MFR_ID  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH = 1'd1;

    // control word bits
    localparam int unsigned CW_MODE_SET = 7;
    localparam int unsigned CW_A_IN     = 4;
    localparam int unsigned CW_C_HI_IN  = 3;
    localparam int unsigned CW_B_IN     = 1;
    localparam int unsigned CW_C_LO_IN  = 0;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_VSYNC = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // port select from address bits {11, 9, 8}
    typedef enum logic [2:0] {
        SEL_A    = 3'b000,
        SEL_B    = 3'b001,
        SEL_C    = 3'b010,
        SEL_CTRL = 3'b011
    } t_sel;

    typedef struct packed {
        logic       vsync_level;
        logic [7:0] key_data;
        logic [7:0] write_data;
        logic [15:0] address;
        t_kind      kind;
    } t_item;

    typedef struct packed {
        logic [3:0] row_select;
        logic       row_strobe;
        logic [7:0] read_data;
        logic       handled;
    } t_result;

    typedef struct packed {
        logic [2:0] manufacturer_id;
        logic       refresh_50hz;
    } t_cfg;

endpackage
`default_nettype wire

>>> rtl/core/ppic_core.sv
`default_nettype none
module ppic_core
    import ppic_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_fire,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result o_result
);

    logic [7:0] r_port_a, n_port_a;
    logic [7:0] r_port_b, n_port_b;
    logic [7:0] r_port_c, n_port_c;
    logic [7:0] r_ctrl,   n_ctrl;
    logic       r_vsync,  n_vsync;

    logic [2:0] sel_bits;
    logic [7:0] bsr_mask;
    logic [7:0] b_source;

    assign sel_bits = {i_item.address[11], i_item.address[9], i_item.address[8]};
    assign bsr_mask = 8'(1) << i_item.write_data[3:1];
    assign b_source = {3'b000, i_cfg.refresh_50hz, i_cfg.manufacturer_id, r_vsync};

    always_comb begin
        n_port_a = r_port_a;
        n_port_b = r_port_b;
        n_port_c = r_port_c;
        n_ctrl   = r_ctrl;
        n_vsync  = r_vsync;
        o_result = '0;
        unique case (i_item.kind)
            KIND_READ: begin
                unique case (sel_bits)
                    SEL_A: begin
                        o_result.handled   = 1'b1;
                        o_result.read_data = r_ctrl[CW_A_IN] ? i_item.key_data : r_port_a;
                    end
                    SEL_B: begin
                        o_result.handled = 1'b1;
                        if (r_ctrl[CW_B_IN]) begin
                            n_port_b           = b_source;
                            o_result.read_data = b_source;
                        end else begin
                            o_result.read_data = r_port_b;
                        end
                    end
                    SEL_C: begin
                        o_result.handled   = 1'b1;
                        o_result.read_data = (r_ctrl[CW_C_LO_IN] || r_ctrl[CW_C_HI_IN])
                                             ? 8'h00 : r_port_c;
                    end
                    default: ;
                endcase
            end
            KIND_WRITE: begin
                unique case (sel_bits)
                    SEL_A: begin
                        o_result.handled = 1'b1;
                        n_port_a         = i_item.write_data;
                    end
                    SEL_C: begin
                        o_result.handled = 1'b1;
                        n_port_c         = i_item.write_data;
                        if (!r_ctrl[CW_C_LO_IN]) begin
                            o_result.row_strobe = 1'b1;
                            o_result.row_select = i_item.write_data[3:0];
                        end
                    end
                    SEL_CTRL: begin
                        o_result.handled = 1'b1;
                        if (i_item.write_data[CW_MODE_SET]) begin
                            // mode set clears every port latch
                            n_ctrl   = i_item.write_data;
                            n_port_a = '0;
                            n_port_b = '0;
                            n_port_c = '0;
                        end else if (i_item.write_data[0]) begin
                            n_port_c = r_port_c | bsr_mask;
                        end else begin
                            n_port_c = r_port_c & ~bsr_mask;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_VSYNC: n_vsync = i_item.vsync_level;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_a <= '0;
            r_port_b <= '0;
            r_port_c <= '0;
            r_ctrl   <= '0;
            r_vsync  <= 1'b0;
        end else if (i_fire) begin
            r_port_a <= n_port_a;
            r_port_b <= n_port_b;
            r_port_c <= n_port_c;
            r_ctrl   <= n_ctrl;
            r_vsync  <= n_vsync;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/ppi_port_controller_top.sv
// Parallel port controller, three 8-bit ports plus a control word.
// Slave stream: one bus access per beat. tuser carries the access kind
// (read, write, vsync update); tdata carries address, write byte, keyboard
// byte and vsync level. Master stream: one result beat per accepted access
// (handled flag, read byte, keyboard row strobe and row number).
// Configuration: write enable, index and data; index 0 sets the maker id,
// index 1 the refresh selection. Write only while the block is idle.
// An access is taken into the input register, then its result into
// the result register. Throughput: one access per cycle unless the
// receiver stalls; the port latches are read and updated in the single
// decode stage between the two registers, so each access sees the state
// left by the previous. Reset clears the port latches, control word and
// vsync flag, and loads the configuration defaults. While the receiver
// stalls, the result beat holds and one more access is taken into the
// input register; after that o_s_tready drops until the result is taken.
`default_nettype none
module ppi_port_controller_top
    import ppic_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    // address[15:0], write_data[23:16], key_data[31:24], vsync_level[32], zero fill
    input  wire  [IN_DATA_W-1:0]  i_s_tdata,
    // kind[1:0]
    input  wire  [IN_USER_W-1:0]  i_s_tuser,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    // handled[0], read_data[8:1], row_strobe[9], row_select[13:10], zero fill
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_result;
    t_cfg    r_cfg;
    t_result core_result;
    logic    out_advance;
    logic    core_fire;

    assign out_advance = !r_out_valid || i_m_tready;
    assign core_fire   = r_in_valid && out_advance;
    assign o_s_tready  = !r_in_valid || out_advance;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {2'b00, r_out_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.manufacturer_id <= MFR_ID_RESET;
            r_cfg.refresh_50hz    <= REFRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MFR_ID:  r_cfg.manufacturer_id <= i_cfg_data;
                CFG_REFRESH: r_cfg.refresh_50hz    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_item.kind        <= t_kind'(i_s_tuser);
            r_in_item.address     <= i_s_tdata[15:0];
            r_in_item.write_data  <= i_s_tdata[23:16];
            r_in_item.key_data    <= i_s_tdata[31:24];
            r_in_item.vsync_level <= i_s_tdata[32];
        end
    end

    ppic_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (core_fire),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_fire) begin
            r_out_result <= core_result;
        end
    end

    a_strobe_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_result.row_strobe |-> r_out_result.handled)
        else $error("row strobe on an unhandled access");

    a_row_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_result.row_select != 4'd0) |-> r_out_result.row_strobe)
        else $error("row number without strobe");

    a_rdata_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_result.read_data != 8'd0) |-> r_out_result.handled)
        else $error("read data on an unhandled access");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("beat taken while both stages are full");

endmodule
`default_nettype wire
